// File: src/efd_pkg.sv
// Shared types and constants for the escaped file frame deframer.
package efd_pkg;

  localparam int NAME_BUFFER_SIZE_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] MARK_FRAME = 8'h7E;
  localparam logic [7:0] MARK_ESCAPE = 8'h7D;
  localparam logic [7:0] MARK_SEPARATOR = 8'h7C;
  localparam logic [7:0] ESCAPE_FLIP = 8'h20;
  localparam logic [2:0] SIZE_BYTES = 3'd4;

  typedef enum logic [2:0] {
    CL_FRAME  = 3'd0,
    CL_ESCAPE = 3'd1,
    CL_SEP    = 3'd2,
    CL_NAME   = 3'd3,
    CL_OTHER  = 3'd4
  } byte_class_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_RESTART     = 3'd1,
    EV_NAME_CHAR   = 3'd2,
    EV_NAME_DONE   = 3'd3,
    EV_HEADER_DONE = 3'd4,
    EV_CONTENT     = 3'd5,
    EV_EOF         = 3'd6,
    EV_ERROR       = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    ERR_TOO_LONG = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_BAD_CHAR = 2'd2,
    ERR_NO_SEP   = 2'd3
  } error_t;

  typedef struct packed {
    logic [7:0]  value;
    byte_class_t kind;
  } item_t;

endpackage

// File: src/escaped_file_frame_deframer.sv
// Top level of the escaped file frame deframer: classifier, queue and parser.
// A byte accepted is first written into the queue, then parsed into the result register.
// Throughput: one byte per cycle while out_ready is held high; a result waiting for out_ready stalls the parser.
// The two-entry queue lets input keep flowing while a result waits for out_ready.
// Reset (rst, synchronous) empties the queue and the result register and
// returns the parser to the name phase with all counters cleared.
module escaped_file_frame_deframer import efd_pkg::*; #(
  parameter int NAME_BUFFER_SIZE = NAME_BUFFER_SIZE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [7:0]  name_length,
  output logic [31:0] file_size,
  output logic [1:0]  error_code
);

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  avail;
  item_t pop_item;

  efd_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  efd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .avail     (avail),
    .pop_item  (pop_item)
  );

  efd_back #(
    .NAME_BUFFER_SIZE (NAME_BUFFER_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (avail),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .data_byte   (data_byte),
    .name_length (name_length),
    .file_size   (file_size),
    .error_code  (error_code)
  );

endmodule

// File: src/efd_front.sv
// Front end: accepts received bytes and tags each with its character class.
module efd_front import efd_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output item_t       push_item,
  input  logic        queue_full
);

  byte_class_t kind;

  always_comb begin
    if (rx_byte == MARK_FRAME) begin
      kind = CL_FRAME;
    end else if (rx_byte == MARK_ESCAPE) begin
      kind = CL_ESCAPE;
    end else if (rx_byte == MARK_SEPARATOR) begin
      kind = CL_SEP;
    end else if (rx_byte inside {["A":"Z"], ["0":"9"], ".", ",", ":", "-", "_"}) begin
      kind = CL_NAME;
    end else begin
      kind = CL_OTHER;
    end
  end

  assign in_ready = !queue_full;
  assign push = in_valid && !queue_full;
  assign push_item = '{value: rx_byte, kind: kind};

endmodule

// File: src/efd_queue.sv
// Short queue of classified bytes between the front end and the parser.
module efd_queue import efd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/efd_back.sv
// Parser: runs the frame state machine and holds the result register.
module efd_back import efd_pkg::*; #(
  parameter int NAME_BUFFER_SIZE = NAME_BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  item_t       pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [7:0]  name_length,
  output logic [31:0] file_size,
  output logic [1:0]  error_code
);

  typedef enum logic [3:0] {
    PH_NAME    = 4'b0001,
    PH_SIZE    = 4'b0010,
    PH_CONTENT = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  name_count, name_count_next;
  logic [2:0]  size_count, size_count_next;
  logic [31:0] size_accum, size_accum_next;
  logic        escape_pending, escape_pending_next;

  event_t      ev;
  logic [7:0]  data_val;
  logic [7:0]  len_val;
  logic [31:0] size_val;
  error_t      err_val;
  logic [8:0]  name_inc;

  assign pop = avail && (!out_valid || out_ready);
  assign name_inc = {1'b0, name_count} + 9'd1;

  always_comb begin
    phase_next = phase;
    name_count_next = name_count;
    size_count_next = size_count;
    size_accum_next = size_accum;
    escape_pending_next = escape_pending;
    ev = EV_NONE;
    data_val = '0;
    len_val = '0;
    size_val = '0;
    err_val = ERR_TOO_LONG;
    case (phase)
      PH_NAME: begin
        case (pop_item.kind)
          CL_FRAME: begin
            name_count_next = '0;
            ev = EV_RESTART;
          end
          CL_NAME: begin
            if (name_inc >= 9'(NAME_BUFFER_SIZE)) begin
              phase_next = PH_DISCARD;
              ev = EV_ERROR;
              err_val = ERR_TOO_LONG;
            end else begin
              name_count_next = name_inc[7:0];
              ev = EV_NAME_CHAR;
              data_val = pop_item.value;
            end
          end
          CL_SEP: begin
            if (name_count == '0) begin
              phase_next = PH_DISCARD;
              ev = EV_ERROR;
              err_val = ERR_EMPTY;
            end else begin
              ev = EV_NAME_DONE;
              len_val = name_count;
              phase_next = PH_SIZE;
              size_count_next = '0;
              size_accum_next = '0;
            end
          end
          default: begin
            phase_next = PH_DISCARD;
            ev = EV_ERROR;
            err_val = ERR_BAD_CHAR;
          end
        endcase
      end
      PH_SIZE: begin
        if (size_count < SIZE_BYTES) begin
          size_accum_next = {size_accum[23:0], pop_item.value};
          size_count_next = size_count + 3'd1;
        end else if (pop_item.kind == CL_SEP) begin
          ev = EV_HEADER_DONE;
          size_val = size_accum;
          phase_next = PH_CONTENT;
          escape_pending_next = 1'b0;
        end else begin
          phase_next = PH_DISCARD;
          ev = EV_ERROR;
          err_val = ERR_NO_SEP;
        end
      end
      PH_CONTENT: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          ev = EV_CONTENT;
          data_val = pop_item.value ^ ESCAPE_FLIP;
        end else if (pop_item.kind == CL_ESCAPE) begin
          escape_pending_next = 1'b1;
        end else if (pop_item.kind == CL_FRAME) begin
          ev = EV_EOF;
          phase_next = PH_NAME;
          name_count_next = '0;
        end else begin
          ev = EV_CONTENT;
          data_val = pop_item.value;
        end
      end
      default: begin
        if (pop_item.kind == CL_FRAME) begin
          ev = EV_RESTART;
          phase_next = PH_NAME;
          name_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NAME;
      name_count <= '0;
      size_count <= '0;
      size_accum <= '0;
      escape_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        name_count <= name_count_next;
        size_count <= size_count_next;
        size_accum <= size_accum_next;
        escape_pending <= escape_pending_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result fields need no reset; out_valid qualifies them.
  always_ff @(posedge clk) begin
    if (pop) begin
      event_res <= ev;
      data_byte <= data_val;
      name_length <= len_val;
      file_size <= size_val;
      error_code <= (ev == EV_ERROR) ? err_val : 2'd0;
    end
  end

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    32'(name_count) < NAME_BUFFER_SIZE)
    else $error("name count reached the buffer size");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size_count <= SIZE_BYTES)
    else $error("size byte count overran");

  a_escape_in_content: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> phase == PH_CONTENT)
    else $error("escape pending outside content");

  a_header_done: assert property (@(posedge clk) disable iff (rst)
    (pop && phase == PH_SIZE && size_count == SIZE_BYTES && pop_item.kind == CL_SEP)
    |=> (phase == PH_CONTENT && event_res == EV_HEADER_DONE))
    else $error("header completion did not enter content");

endmodule

// File: verif/efd_result_checker.sv
// Result checker for the escaped file frame deframer: predicts each result and compares it.
module efd_result_checker import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  event_res,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  name_length,
  input  logic [31:0] file_size,
  input  logic [1:0]  error_code,
  output int          mismatch_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PARSE_NAME    = 2'd0,
    PARSE_SIZE    = 2'd1,
    PARSE_CONTENT = 2'd2,
    PARSE_DISCARD = 2'd3
  } parse_phase_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [7:0]  name_len;
    logic [31:0] size;
    error_t      err;
  } deframe_result_t;

  parse_phase_t    parse_phase = PARSE_NAME;
  logic [7:0]      name_chars = '0;
  logic [2:0]      size_bytes_seen = '0;
  logic [31:0]     size_shift = '0;
  logic            escape_armed = 1'b0;
  deframe_result_t expected_results[$];
  deframe_result_t seen, want;
  int              mismatches = 0;

  function automatic logic is_name_char(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
           b == "." || b == "," || b == ":" || b == "-" || b == "_";
  endfunction

  // Advances the parser state by one byte and returns the result it causes.
  function automatic deframe_result_t parse_byte(input logic [7:0] b);
    deframe_result_t r;
    r = '{ev: EV_NONE, data: 8'h00, name_len: 8'h00, size: 32'h0, err: ERR_TOO_LONG};
    case (parse_phase)
      PARSE_NAME: begin
        if (b == MARK_FRAME) begin
          name_chars = '0;
          r.ev = EV_RESTART;
        end else if (is_name_char(b)) begin
          if (name_chars + 1 >= NAME_BUFFER_SIZE_DEF) begin
            parse_phase = PARSE_DISCARD;
            r.ev = EV_ERROR;
            r.err = ERR_TOO_LONG;
          end else begin
            name_chars = name_chars + 8'd1;
            r.ev = EV_NAME_CHAR;
            r.data = b;
          end
        end else if (b == MARK_SEPARATOR) begin
          if (name_chars == 0) begin
            parse_phase = PARSE_DISCARD;
            r.ev = EV_ERROR;
            r.err = ERR_EMPTY;
          end else begin
            r.ev = EV_NAME_DONE;
            r.name_len = name_chars;
            parse_phase = PARSE_SIZE;
            size_bytes_seen = '0;
            size_shift = '0;
          end
        end else begin
          parse_phase = PARSE_DISCARD;
          r.ev = EV_ERROR;
          r.err = ERR_BAD_CHAR;
        end
      end
      PARSE_SIZE: begin
        if (size_bytes_seen < SIZE_BYTES) begin
          size_shift = {size_shift[23:0], b};
          size_bytes_seen = size_bytes_seen + 3'd1;
        end else if (b == MARK_SEPARATOR) begin
          r.ev = EV_HEADER_DONE;
          r.size = size_shift;
          parse_phase = PARSE_CONTENT;
          escape_armed = 1'b0;
        end else begin
          parse_phase = PARSE_DISCARD;
          r.ev = EV_ERROR;
          r.err = ERR_NO_SEP;
        end
      end
      PARSE_CONTENT: begin
        if (escape_armed) begin
          escape_armed = 1'b0;
          r.ev = EV_CONTENT;
          r.data = b ^ ESCAPE_FLIP;
        end else if (b == MARK_ESCAPE) begin
          escape_armed = 1'b1;
        end else if (b == MARK_FRAME) begin
          r.ev = EV_EOF;
          parse_phase = PARSE_NAME;
          name_chars = '0;
        end else begin
          r.ev = EV_CONTENT;
          r.data = b;
        end
      end
      default: begin
        if (b == MARK_FRAME) begin
          r.ev = EV_RESTART;
          parse_phase = PARSE_NAME;
          name_chars = '0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PARSE_NAME;
      name_chars = '0;
      size_bytes_seen = '0;
      size_shift = '0;
      escape_armed = 1'b0;
      expected_results.delete();
    end else begin
      // The result side is checked first so that a byte accepted at this edge
      // can never be matched against a result leaving at the same edge.
      if (out_valid && out_ready) begin
        seen = '{event_t'(event_res), data_byte, name_length, file_size, error_t'(error_code)};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: event %0d data %h len %0d size %h err %0d",
                   $time, seen.ev, seen.data, seen.name_len, seen.size, seen.err);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch: expected event %0d data %h len %0d size %h err %0d",
                     $time, want.ev, want.data, want.name_len, want.size, want.err);
            $display("%0t:                  actual   event %0d data %h len %0d size %h err %0d",
                     $time, seen.ev, seen.data, seen.name_len, seen.size, seen.err);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(parse_byte(rx_byte));
      end
    end
    mismatch_count <= mismatches;
    pending_results <= expected_results.size();
  end

endmodule

// File: verif/escaped_file_frame_deframer_test.sv
// Testbench top for the escaped file frame deframer: stimulus, idling and verdict.
module escaped_file_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import efd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTES_PER_PHASE = 430;
  localparam string NAME_EXTRAS = ".,:-_";

  // Empty name, bad character, a full frame with extreme size and escapes,
  // and a header whose size is not followed by a separator.
  localparam logic [7:0] DIRECTED_STREAM [28] = '{
    MARK_SEPARATOR, 8'h00, MARK_FRAME, 8'h40, MARK_FRAME,
    "Z", "9", MARK_SEPARATOR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, MARK_SEPARATOR,
    8'h00, 8'hFF, MARK_ESCAPE, MARK_FRAME, MARK_ESCAPE, MARK_ESCAPE, MARK_FRAME,
    "_", MARK_SEPARATOR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MARK_FRAME
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  name_length;
  logic [31:0] file_size;
  logic [1:0]  error_code;
  int          mismatch_count;
  int          pending_results;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;

  escaped_file_frame_deframer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .data_byte(data_byte), .name_length(name_length),
    .file_size(file_size), .error_code(error_code)
  );

  efd_result_checker checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .data_byte(data_byte), .name_length(name_length),
    .file_size(file_size), .error_code(error_code),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("escaped_file_frame_deframer_test failed");
      $finish;
    end
  end

  // Offers one byte, with random idle cycles ahead of it, and waits for the transaction.
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Holds the sender off until every predicted result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_name_char();
    int k;
    k = $urandom_range(40, 0);
    if (k < 26) return 8'("A" + k);
    if (k < 36) return 8'("0" + k - 26);
    return NAME_EXTRAS[k - 36];
  endfunction

  task automatic send_noise();
    int count;
    count = $urandom_range(8, 1);
    repeat (count) send_rx_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic send_file_frame();
    int          pick, name_len, body_len;
    logic [31:0] size;
    logic [7:0]  b;
    pick = $urandom_range(99, 0);
    if ($urandom_range(9, 0) < 7) send_rx_byte(MARK_FRAME);
    if (pick < 4) name_len = 0;
    else if (pick < 8) name_len = NAME_BUFFER_SIZE_DEF;
    else if (pick < 12) name_len = NAME_BUFFER_SIZE_DEF - 1;
    else name_len = $urandom_range(6, 1);
    repeat (name_len) send_rx_byte(pick_name_char());
    send_rx_byte(MARK_SEPARATOR);
    case ($urandom_range(3, 0))
      0: size = 32'h0000_0000;
      1: size = 32'hFFFF_FFFF;
      default: size = $urandom;
    endcase
    for (int k = 3; k >= 0; k--) send_rx_byte(size[8*k +: 8]);
    if ($urandom_range(9, 0) == 0) begin
      do b = 8'($urandom_range(255, 0)); while (b == MARK_SEPARATOR);
      send_rx_byte(b);
    end else begin
      send_rx_byte(MARK_SEPARATOR);
    end
    body_len = $urandom_range(12, 0);
    repeat (body_len) begin
      if ($urandom_range(4, 0) == 0) begin
        send_rx_byte(MARK_ESCAPE);
        case ($urandom_range(3, 0))
          0: send_rx_byte(MARK_FRAME);
          1: send_rx_byte(MARK_ESCAPE);
          default: send_rx_byte(8'($urandom_range(255, 0)));
        endcase
      end else begin
        do b = 8'($urandom_range(255, 0)); while (b == MARK_ESCAPE || b == MARK_FRAME);
        send_rx_byte(b);
      end
    end
    send_rx_byte(MARK_FRAME);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
      case (phase_idx)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase_idx == 0) begin
        foreach (DIRECTED_STREAM[i]) send_rx_byte(DIRECTED_STREAM[i]);
        drain_results();
      end
      while (bytes_sent < BYTES_PER_PHASE * (phase_idx + 1)) begin
        if ($urandom_range(9, 0) == 0) send_noise();
        else send_file_frame();
      end
      drain_results();
    end
    repeat (8) @(posedge clk);
    if (pending_results != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results);
    end
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("escaped_file_frame_deframer_test passed");
    end else begin
      $display("escaped_file_frame_deframer_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/efd_pkg.sv
src/efd_front.sv
src/efd_queue.sv
src/efd_back.sv
src/escaped_file_frame_deframer.sv
verif/efd_result_checker.sv
verif/escaped_file_frame_deframer_test.sv
